### hw/rtl/timed_event_queue_macros.svh
// Assertion macros for the timed event queue.
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TEQ_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);
`else
`define TEQ_ASSERT(lbl, cond, msg)
`define TEQ_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

### hw/rtl/teq_pkg.sv
// Shared constants, codes and types of the timed event queue.
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TIME_W = 32;
	localparam int TAG_W  = 16;
	localparam int CMD_W  = 2;
	localparam int KIND_W = 3;
	localparam int REM_W  = 6;

	localparam logic [CMD_W-1:0] CMD_INS   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADV   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CAN   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DUE      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NONE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd5;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [TAG_W-1:0]  op;
		logic [TAG_W-1:0]  param;
		logic [TAG_W-1:0]  group;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

### hw/rtl/teq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module teq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/timed_event_queue.sv
// Top level of the timed event queue: sorted ring of entries in one RAM.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | cmd, time_value, relative, tags, skip
//  out     | output    | out_valid / out_ready| kind, due_*, lateness, removed_count, last
//
// One item at a time. Insert walks down from the tail, one RAM read per entry;
// cancel runs a compaction walk; advance pops one due entry per cycle while the
// output is not stalled; clear resets the queue state directly.
// The single-read-port entry RAM is why each walk reads one entry at a time.
// Reset empties the queue and zeroes the time; no clearing pass is needed.
// A stalled output holds the advance walk; a new item is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "timed_event_queue_macros.svh"
module timed_event_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [teq_pkg::CMD_W-1:0]   cmd,
	input  logic [teq_pkg::TIME_W-1:0]  time_value,
	input  logic                        relative,
	input  logic [teq_pkg::TAG_W-1:0]   op_handle,
	input  logic [teq_pkg::TAG_W-1:0]   param_handle,
	input  logic [teq_pkg::TAG_W-1:0]   group_id,
	input  logic                        skip,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [teq_pkg::KIND_W-1:0]  kind,
	output logic [teq_pkg::TAG_W-1:0]   due_op,
	output logic [teq_pkg::TAG_W-1:0]   due_param,
	output logic [teq_pkg::TAG_W-1:0]   due_group,
	output logic [teq_pkg::TIME_W-1:0]  lateness,
	output logic                        was_skipped,
	output logic [teq_pkg::REM_W-1:0]   removed_count,
	output logic                        last
);
	import teq_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS      = 3'd1;
	localparam logic [2:0] S_INS_LAST = 3'd2;
	localparam logic [2:0] S_CHK      = 3'd3;
	localparam logic [2:0] S_FIN      = 3'd4;
	localparam logic [2:0] S_CAN      = 3'd5;
	localparam logic [2:0] S_RESP     = 3'd6;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  used_q;
	logic [TIME_W-1:0] cur_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  w_q;
	logic [REM_W-1:0]  rem_q;
	logic [KIND_W-1:0] kind_q;
	entry_t            new_q;
	logic              skip_q;
	entry_t            cand_q;
	logic [TIME_W-1:0] cand_late_q;
	logic              have_cand_q;
	logic              out_valid_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  raddr;
	entry_t            wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t            rd;

	logic              out_free;
	logic              accept;
	logic              ins_stop;
	logic              due;
	logic              pop;
	logic              keep;
	logic [CNT_W-1:0]  used_m1;

	logic              load;
	logic [KIND_W-1:0] ld_kind;
	entry_t            ld_ent;
	logic [TIME_W-1:0] ld_late;
	logic              ld_skip;
	logic [REM_W-1:0]  ld_rem;
	logic              ld_last;

	teq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd       = entry_t'(rdata);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign used_m1  = used_q - CNT_W'(1);
	assign ins_stop = new_q.due > rd.due;
	assign due      = rd.due <= cur_q;
	assign pop      = (state_q == S_CHK) && due && (!have_cand_q || out_free);
	assign keep     = rd.group != new_q.group;

	// RAM addressing and result selection
	always_comb begin
		raddr   = head_q;
		we      = 1'b0;
		waddr   = head_q;
		wdata   = rd;
		load    = 1'b0;
		ld_kind = kind_q;
		ld_ent  = '0;
		ld_late = '0;
		ld_skip = 1'b0;
		ld_rem  = '0;
		ld_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd == CMD_INS) begin
					raddr = head_q + used_m1[IDX_W-1:0];
				end
			end
			S_INS: begin
				we    = 1'b1;
				waddr = head_q + idx_q + IDX_W'(1);
				wdata = ins_stop ? new_q : rd;
				raddr = head_q + idx_q - IDX_W'(1);
			end
			S_INS_LAST: begin
				we    = 1'b1;
				waddr = head_q;
				wdata = new_q;
			end
			S_CHK: begin
				raddr = pop ? head_q + IDX_W'(1) : head_q;
				if (pop && have_cand_q) begin
					load    = 1'b1;
					ld_kind = KIND_DUE;
					ld_ent  = cand_q;
					ld_late = cand_late_q;
					ld_skip = skip_q;
					ld_last = 1'b0;
				end
			end
			S_FIN: begin
				load = out_free;
				if (have_cand_q) begin
					ld_kind = KIND_DUE;
					ld_ent  = cand_q;
					ld_late = cand_late_q;
					ld_skip = skip_q;
				end else begin
					ld_kind = KIND_NONE;
				end
			end
			S_CAN: begin
				raddr = head_q + idx_q + IDX_W'(1);
				we    = keep;
				waddr = head_q + w_q[IDX_W-1:0];
			end
			S_RESP: begin
				load   = out_free;
				ld_rem = rem_q;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			used_q      <= '0;
			cur_q       <= '0;
			have_cand_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_INS: begin
								if (used_q == CNT_W'(DEPTH)) begin
									state_q <= S_RESP;
								end else if (used_q == '0) begin
									state_q <= S_INS_LAST;
								end else begin
									state_q <= S_INS;
								end
							end
							CMD_ADV: begin
								cur_q       <= cur_q + time_value;
								have_cand_q <= 1'b0;
								state_q     <= (used_q == '0) ? S_FIN : S_CHK;
							end
							CMD_CAN: begin
								state_q <= (used_q == '0) ? S_RESP : S_CAN;
							end
							default: begin
								used_q  <= '0;
								head_q  <= '0;
								cur_q   <= '0;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_INS: begin
					if (ins_stop) begin
						used_q  <= used_q + CNT_W'(1);
						state_q <= S_RESP;
					end else if (idx_q == '0) begin
						state_q <= S_INS_LAST;
					end
				end
				S_INS_LAST: begin
					used_q  <= used_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_CHK: begin
					if (pop) begin
						have_cand_q <= 1'b1;
						head_q      <= head_q + IDX_W'(1);
						used_q      <= used_m1;
						if (used_q == CNT_W'(1)) begin
							state_q <= S_FIN;
						end
					end else if (!due) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						have_cand_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_CAN: begin
					if ({1'b0, idx_q} == used_m1) begin
						used_q  <= keep ? w_q + CNT_W'(1) : w_q;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.due   <= relative ? time_value + cur_q : time_value;
			new_q.op    <= op_handle;
			new_q.param <= param_handle;
			new_q.group <= group_id;
			skip_q      <= skip;
			idx_q       <= (cmd == CMD_INS) ? used_m1[IDX_W-1:0] : '0;
			w_q         <= '0;
			rem_q       <= '0;
			case (cmd)
				CMD_INS:   kind_q <= (used_q == CNT_W'(DEPTH)) ? KIND_FULL : KIND_INSERTED;
				CMD_CAN:   kind_q <= KIND_CANCEL;
				default:   kind_q <= KIND_CLEARED;
			endcase
		end
		if (state_q == S_INS) begin
			idx_q <= idx_q - IDX_W'(1);
		end
		if (state_q == S_CAN) begin
			idx_q <= idx_q + IDX_W'(1);
			if (keep) begin
				w_q <= w_q + CNT_W'(1);
			end else begin
				rem_q <= rem_q + REM_W'(1);
			end
		end
		if (pop) begin
			cand_q      <= rd;
			cand_late_q <= cur_q - rd.due;
		end
		if (load) begin
			kind          <= ld_kind;
			due_op        <= ld_ent.op;
			due_param     <= ld_ent.param;
			due_group     <= ld_ent.group;
			lateness      <= ld_late;
			was_skipped   <= ld_skip;
			removed_count <= ld_rem;
			last          <= ld_last;
		end
	end

	assign out_valid = out_valid_q;

	`TEQ_ASSERT(a_used_bound, used_q <= CNT_W'(DEPTH), "entry count beyond queue depth")
	`TEQ_ASSERT(a_cand_adv, !have_cand_q || state_q == S_CHK || state_q == S_FIN, "held entry outside advance")
	`TEQ_ASSERT(a_ins_room, state_q != S_INS || used_q < CNT_W'(DEPTH), "insert walk on a full queue")
	`TEQ_ASSERT_NEXT(a_clear, accept && cmd == CMD_CLEAR, used_q == '0 && cur_q == '0, "clear left state behind")
endmodule
`default_nettype wire
